FILE: rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// shared types and constants of the stereo chorus delay core
// ----------------------------------------------------------------------------
package scd_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_L    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_R    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_L     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_R     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MIX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK   = 3'd7;

    // register reset values
    localparam logic [23:0] RST_PHASE_STEP = 24'd89478;
    localparam logic [19:0] RST_BASE       = 20'd6144;
    localparam logic [31:0] RST_PHASE_OFF  = 32'h4000_0000;

    // q16 unity
    localparam logic [16:0] Q16_ONE = 17'd65536;

    // odd sine polynomial coefficients, q30
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598669;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026996;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic start;
        logic lfo;
        logic sin;
        logic mixa;
        logic mixb;
        logic dly;
        logic sat;
        logic addr;
        logic rd_nxt;
        logic cap_a;
        logic intp;
        logic fb;
        logic done;
        logic ch;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/scd_in_if.sv
// ----------------------------------------------------------------------------
// scd_in_if
// input channel: one dry stereo word per handshake
// ----------------------------------------------------------------------------
interface scd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

FILE: rtl/scd_out_if.sv
// ----------------------------------------------------------------------------
// scd_out_if
// output channel: one wet stereo word per handshake
// ----------------------------------------------------------------------------
interface scd_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] wet_left;
    logic signed [SAMPLE_BITS-1:0] wet_right;

    modport source (output valid, output wet_left, output wet_right, input ready);
    modport sink   (input valid, input wet_left, input wet_right, output ready);
endinterface

FILE: rtl/scd_line.sv
// ----------------------------------------------------------------------------
// scd_line
// one delay line memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module scd_line #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/scd_ctrl.sv
// ----------------------------------------------------------------------------
// scd_ctrl
// sequencer: clearing pass, then per word the left and right channel steps
// ----------------------------------------------------------------------------
module scd_ctrl
    import scd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LFO, S_SIN, S_MIXA, S_MIXB, S_DLY, S_SAT,
        S_ADDR, S_RDA, S_RDB, S_INT, S_FB, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ch;
    logic   n_ch;

    // command decode and next state
    always_comb begin
        o_cmd    = '0;
        o_cmd.ch = r_ch;
        n_state  = r_state;
        n_ch     = r_ch;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_ch        = 1'b0;
                    n_state     = S_LFO;
                end
            end
            S_LFO:  begin o_cmd.lfo  = 1'b1; n_state = S_SIN;  end
            S_SIN:  begin o_cmd.sin  = 1'b1; n_state = S_MIXA; end
            S_MIXA: begin o_cmd.mixa = 1'b1; n_state = S_MIXB; end
            S_MIXB: begin o_cmd.mixb = 1'b1; n_state = S_DLY;  end
            S_DLY:  begin o_cmd.dly  = 1'b1; n_state = S_SAT;  end
            S_SAT:  begin o_cmd.sat  = 1'b1; n_state = S_ADDR; end
            S_ADDR: begin o_cmd.addr = 1'b1; n_state = S_RDA;  end
            S_RDA:  n_state = S_RDB;
            S_RDB: begin
                o_cmd.rd_nxt = 1'b1;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_INT;
            end
            S_INT:  begin o_cmd.intp = 1'b1; n_state = S_FB; end
            S_FB: begin
                o_cmd.fb = 1'b1;
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_LFO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // a word is taken only from idle, the right channel follows the left, and a word finishes only on the right channel
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (r_state == S_IDLE))
        else $error("word taken outside idle");
    a_right_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fb && !r_ch) |=> (r_ch && r_state == S_LFO))
        else $error("right channel not started after left");
    a_done_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |-> r_ch)
        else $error("word finished before right channel");
endmodule

FILE: rtl/scd_datapath.sv
// ----------------------------------------------------------------------------
// scd_datapath
// config registers, lfo, delay address, interpolation, feedback and lines
// ----------------------------------------------------------------------------
module scd_datapath
    import scd_pkg::*;
#(
    parameter int LINE_DEPTH   = 4096,
    parameter int SAMPLE_BITS  = 24,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_wet_left,
    output logic signed [SAMPLE_BITS-1:0] o_wet_right
);
    localparam int AW   = $clog2(LINE_DEPTH);
    localparam int PW   = (AW + 10 > 22) ? AW + 10 : 22;
    localparam int IW   = $clog2(SINE_ENTRIES + 1);
    localparam int SPW  = 31 + IW + 1;
    localparam int SB   = SAMPLE_BITS;
    localparam logic [PW-1:0] SPAN     = PW'(LINE_DEPTH) << 8;
    localparam logic [PW-1:0] MIN_DLY  = PW'(256);
    localparam logic [AW-1:0] LAST     = AW'(LINE_DEPTH - 1);
    localparam logic [SPW-1:0] HALF_ST = SPW'(1) << 29;

    // configuration registers
    logic [23:0]        r_phase_step;
    logic [17:0]        r_depth_l, r_depth_r;
    logic [19:0]        r_base_l, r_base_r;
    logic [31:0]        r_phase_off;
    logic [16:0]        r_wave_mix;
    logic signed [15:0] r_feedback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_depth_l    <= '0;
            r_depth_r    <= '0;
            r_base_l     <= RST_BASE;
            r_base_r     <= RST_BASE;
            r_phase_off  <= RST_PHASE_OFF;
            r_wave_mix   <= '0;
            r_feedback   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data[23:0];
                CFG_DEPTH_L:    r_depth_l    <= i_cfg_data[17:0];
                CFG_DEPTH_R:    r_depth_r    <= i_cfg_data[17:0];
                CFG_BASE_L:     r_base_l     <= i_cfg_data[19:0];
                CFG_BASE_R:     r_base_r     <= i_cfg_data[19:0];
                CFG_PHASE_OFF:  r_phase_off  <= i_cfg_data;
                CFG_WAVE_MIX:   r_wave_mix   <= i_cfg_data[16:0];
                CFG_FEEDBACK:   r_feedback   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // quarter-wave sine table, built at elaboration
    logic [16:0] w_sine [SINE_ENTRIES + 1];

    for (genvar gi = 0; gi <= SINE_ENTRIES; gi++) begin : g_sine
        localparam logic [63:0] Z  = (64'(gi) << 30) / SINE_ENTRIES;
        localparam logic [63:0] Z2 = (Z * Z) >> 30;
        localparam logic [63:0] R7 = SIN_C7 - ((SIN_C9 * Z2) >> 30);
        localparam logic [63:0] R5 = SIN_C5 - ((R7 * Z2) >> 30);
        localparam logic [63:0] R3 = SIN_C3 - ((R5 * Z2) >> 30);
        localparam logic [63:0] R1 = SIN_C1 - ((R3 * Z2) >> 30);
        localparam logic [63:0] S  = (((Z * R1) >> 30) + 64'd8192) >> 14;
        localparam logic [63:0] SV = (S > 64'd65536) ? 64'd65536 : S;
        assign w_sine[gi] = SV[16:0];
    end

    // datapath registers
    logic [31:0]          r_lfo;
    logic [AW-1:0]        r_slot;
    logic signed [SB-1:0] r_dry_l, r_dry_r;
    logic [16:0]          r_tri;
    logic [1:0]           r_quad;
    logic [IW-1:0]        r_sidx;
    logic [16:0]          r_mag;
    logic [33:0]          r_prod_a;
    logic [16:0]          r_u;
    logic [34:0]          r_dprod;
    logic [PW-1:0]        r_dly;
    logic [AW-1:0]        r_idx, r_nxt;
    logic [7:0]           r_frac;
    logic signed [SB-1:0] r_a;
    logic signed [SB-1:0] r_delayed;
    logic signed [SB-1:0] r_wet_l;
    logic signed [SB-1:0] r_out_l, r_out_r;
    logic                 r_out_valid;

    // channel selection
    logic [31:0]          w_phase;
    logic [17:0]          w_depth;
    logic [19:0]          w_base;
    logic signed [SB-1:0] w_dry;
    logic [SB-1:0]        w_rd_l, w_rd_r;
    logic signed [SB-1:0] w_rdata;

    assign w_phase = i_cmd.ch ? (r_lfo + r_phase_off) : r_lfo;
    assign w_depth = i_cmd.ch ? r_depth_r : r_depth_l;
    assign w_base  = i_cmd.ch ? r_base_r : r_base_l;
    assign w_dry   = i_cmd.ch ? r_dry_r : r_dry_l;
    assign w_rdata = i_cmd.ch ? $signed(w_rd_r) : $signed(w_rd_l);

    // triangle and sine index
    logic [31:0]    w_dist;
    logic [16:0]    w_tri;
    logic [30:0]    w_qpos;
    logic [SPW-1:0] w_sprod;

    assign w_dist  = w_phase[31] ? (32'd0 - w_phase) : w_phase;
    assign w_tri   = (w_phase == 32'h8000_0000) ? Q16_ONE : {1'b0, w_dist[30:15]};
    assign w_qpos  = w_phase[30] ? ((31'd1 << 30) - {1'b0, w_phase[29:0]})
                                 : {1'b0, w_phase[29:0]};
    assign w_sprod = SPW'(w_qpos) * SPW'(SINE_ENTRIES) + HALF_ST;

    // blend weights, unipolar sine needs one extra bit before halving
    logic [16:0] w_mix;
    logic [16:0] w_inv;
    logic [16:0] w_sin_u;

    assign w_mix   = (r_wave_mix > Q16_ONE) ? Q16_ONE : r_wave_mix;
    assign w_inv   = Q16_ONE - w_mix;
    assign w_sin_u = r_quad[1] ? 17'((18'(Q16_ONE) - 18'(r_mag)) >> 1)
                               : 17'((18'(Q16_ONE) + 18'(r_mag)) >> 1);

    // delay saturation and read position
    logic [PW-1:0] w_dsum;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_posw;
    logic [AW-1:0] w_idx;

    assign w_dsum = PW'(w_base) + PW'(r_dprod[34:16]);
    assign w_pos  = (PW'(r_slot) << 8) + SPAN - r_dly;
    assign w_posw = (w_pos >= SPAN) ? (w_pos - SPAN) : w_pos;
    assign w_idx  = w_posw[AW+7:8];

    // interpolation
    logic signed [SB:0]   w_diff;
    logic signed [SB+9:0] w_iprod;
    logic signed [SB+9:0] w_istep;

    assign w_diff  = SB'(w_rdata) - SB'(r_a) == 0 ? '0
                   : ($signed({w_rdata[SB-1], w_rdata}) - $signed({r_a[SB-1], r_a}));
    assign w_iprod = w_diff * $signed({1'b0, r_frac}) + (SB+10)'(128);
    assign w_istep = w_iprod >>> 8;

    // feedback and saturation
    logic signed [SB+15:0] w_fprod;
    logic signed [SB+15:0] w_fb;
    logic signed [SB+1:0]  w_sum;
    logic signed [SB-1:0]  w_wr;
    localparam logic signed [SB+1:0] SMAX = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [SB+1:0] SMIN = {3'b111, {(SB-1){1'b0}}};

    assign w_fprod = r_delayed * r_feedback + (SB+16)'(16384);
    assign w_fb    = w_fprod >>> 15;
    assign w_sum   = (SB+2)'(w_dry) + (SB+2)'(w_fb);
    assign w_wr    = (w_sum > SMAX) ? SMAX[SB-1:0]
                   : ((w_sum < SMIN) ? SMIN[SB-1:0] : w_sum[SB-1:0]);

    // line ports
    logic          w_we_l, w_we_r;
    logic [SB-1:0] w_wdata;
    logic [AW-1:0] w_raddr;

    assign w_we_l  = i_cmd.clear || (i_cmd.fb && !i_cmd.ch);
    assign w_we_r  = i_cmd.clear || (i_cmd.fb && i_cmd.ch);
    assign w_wdata = i_cmd.clear ? '0 : w_wr;
    assign w_raddr = i_cmd.rd_nxt ? r_nxt : r_idx;

    scd_line #(.DEPTH(LINE_DEPTH), .WIDTH(SB)) u_line_l (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_l)
    );

    scd_line #(.DEPTH(LINE_DEPTH), .WIDTH(SB)) u_line_r (
        .i_clk   (i_clk),
        .i_we    (w_we_r),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_r)
    );

    // control state: phase, slot and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) r_lfo <= r_lfo + {8'd0, r_phase_step};
            if (i_cmd.clear || i_cmd.done) begin
                r_slot <= (r_slot == LAST) ? '0 : r_slot + AW'(1);
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dry_l <= i_sample_left;
            r_dry_r <= i_sample_right;
        end
        if (i_cmd.lfo) begin
            r_tri  <= w_tri;
            r_quad <= w_phase[31:30];
            r_sidx <= w_sprod[30+IW-1:30];
        end
        if (i_cmd.sin)  r_mag    <= w_sine[r_sidx];
        if (i_cmd.mixa) r_prod_a <= 34'(r_tri) * 34'(w_inv);
        if (i_cmd.mixb) r_u      <= 17'((r_prod_a + 34'(w_sin_u) * 34'(w_mix)) >> 16);
        if (i_cmd.dly)  r_dprod  <= 35'(r_u) * 35'(w_depth);
        if (i_cmd.sat) begin
            r_dly <= (w_dsum < MIN_DLY) ? MIN_DLY : ((w_dsum > SPAN) ? SPAN : w_dsum);
        end
        if (i_cmd.addr) begin
            r_idx  <= w_idx;
            r_nxt  <= (w_idx == LAST) ? '0 : w_idx + AW'(1);
            r_frac <= w_posw[7:0];
        end
        if (i_cmd.cap_a) r_a       <= w_rdata;
        if (i_cmd.intp)  r_delayed <= r_a + w_istep[SB-1:0];
        if (i_cmd.fb && !i_cmd.ch) r_wet_l <= r_delayed;
        if (i_cmd.done) begin
            r_out_l <= r_wet_l;
            r_out_r <= r_delayed;
        end
    end

    assign o_sts.clear_last = (r_slot == LAST);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_wet_left       = r_out_l;
    assign o_wet_right      = r_out_r;

    // slot wraps, finished word shows up without overwriting a held one, read address stays in the line
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST)
        else $error("write slot beyond line");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |=> r_out_valid)
        else $error("finished word not presented");
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |-> !(r_out_valid && !i_out_ready))
        else $error("output word overwritten");
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.addr |=> (r_idx <= LAST && r_nxt <= LAST))
        else $error("read address beyond line");
endmodule

FILE: rtl/stereo_chorus_delay_core.sv
// Flow: a taken word runs 11 steps per channel, left then right, then a
// hand-over step that waits while the output word is still held; the
// sequencer shares one datapath over both channels, so it takes a new word
// only once the last one has been handed over.
// Reset: synchronous, active low; registers take their reset values, then a
// clearing pass zeroes every slot of both lines before the first word.
// ----------------------------------------------------------------------------
// stereo_chorus_delay_core
// stereo chorus on two lfo-modulated, interpolated delay lines with feedback
// ----------------------------------------------------------------------------
module stereo_chorus_delay_core
    import scd_pkg::*;
#(
    parameter int LINE_DEPTH   = 4096,
    parameter int SAMPLE_BITS  = 24,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    scd_in_if.sink                i_in,
    scd_out_if.source             o_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    scd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    scd_datapath #(
        .LINE_DEPTH   (LINE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_left  (i_in.sample_left),
        .i_sample_right (i_in.sample_right),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_wet_left     (o_out.wet_left),
        .o_wet_right    (o_out.wet_right)
    );
endmodule

FILE: bench/tb_stereo_chorus_delay_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_chorus_delay_core
// checks the stereo chorus core word by word against a bit-true predictor of
// lfo, delay lines and feedback, with random gaps, stalls and register sets
// ----------------------------------------------------------------------------
module tb_stereo_chorus_delay_core;
    import scd_pkg::*;

    localparam int DEPTH   = 4096;
    localparam int SPAN    = DEPTH * 256;
    localparam int ENTRIES = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [23:0] wl;
        logic signed [23:0] wr;
    } t_wet;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    scd_in_if  #(.SAMPLE_BITS(24)) in_ch ();
    scd_out_if #(.SAMPLE_BITS(24)) out_ch ();

    stereo_chorus_delay_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [23:0] m_step;
    logic [17:0] m_depth_l, m_depth_r;
    logic [19:0] m_base_l, m_base_r;
    logic [31:0] m_offset;
    logic [16:0] m_mix;
    logic signed [15:0] m_fb;
    logic signed [23:0] line_l [DEPTH];
    logic signed [23:0] line_r [DEPTH];
    int unsigned slot;
    logic [31:0] phase;
    logic [31:0] sine_tab [ENTRIES+1];

    t_wet wet_queue [$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_rx = 0;
    bit long_rx = 0;
    bit quiet_rx = 0;

    function automatic logic [31:0] quarter_sine(int unsigned i);
        logic [63:0] z, z2, r, s;
        z  = (64'(i) << 30) / ENTRIES;
        z2 = (z * z) >> 30;
        r  = SIN_C9;
        r  = SIN_C7 - ((r * z2) >> 30);
        r  = SIN_C5 - ((r * z2) >> 30);
        r  = SIN_C3 - ((r * z2) >> 30);
        r  = SIN_C1 - ((r * z2) >> 30);
        s  = (((z * r) >> 30) + 64'd8192) >> 14;
        return (s > 64'd65536) ? 32'd65536 : s[31:0];
    endfunction

    function automatic logic [63:0] lfo_level(logic [31:0] p);
        logic [31:0] d, tri_v, mag, sin_u;
        logic [63:0] f, pos, w;
        int unsigned ix;
        d = p[31] ? (32'd0 - p) : p;
        tri_v = (p == 32'h8000_0000) ? 32'd65536 : (d >> 15);
        f = {34'd0, p[29:0]};
        pos = p[30] ? ((64'd1 << 30) - f) : f;
        ix = int'((pos * ENTRIES + (64'd1 << 29)) >> 30);
        mag = sine_tab[ix];
        sin_u = p[31] ? ((32'd65536 - mag) >> 1) : ((32'd65536 + mag) >> 1);
        w = (m_mix > 17'd65536) ? 64'd65536 : 64'(m_mix);
        return ((64'(tri_v) * (64'd65536 - w)) + 64'(sin_u) * w) >> 16;
    endfunction

    // one channel: read interpolated tap, write dry plus feedback, return tap
    function automatic logic signed [23:0] run_channel(bit right,
            logic signed [23:0] dry, logic [31:0] p, logic [19:0] base,
            logic [17:0] dep);
        longint dly, pos, a, b, tap, fbk, nv, frac;
        int unsigned ix, nx;
        dly = longint'(base) + longint'((lfo_level(p) * 64'(dep)) >> 16);
        if (dly < 256) dly = 256;
        if (dly > SPAN) dly = SPAN;
        pos = longint'(slot) * 256 + SPAN - dly;
        if (pos >= SPAN) pos -= SPAN;
        ix = int'(pos >> 8);
        frac = pos & 255;
        nx = (ix + 1 >= DEPTH) ? 0 : ix + 1;
        a = right ? line_r[ix] : line_l[ix];
        b = right ? line_r[nx] : line_l[nx];
        tap = a + (((b - a) * frac + 128) >>> 8);
        fbk = (tap * longint'(m_fb) + 16384) >>> 15;
        nv = longint'(dry) + fbk;
        if (nv > 8388607) nv = 8388607;
        if (nv < -8388608) nv = -8388608;
        if (right) line_r[slot] = nv[23:0];
        else line_l[slot] = nv[23:0];
        return tap[23:0];
    endfunction

    function automatic t_wet predict_wet(logic signed [23:0] sl,
            logic signed [23:0] sr);
        t_wet w;
        phase = phase + 32'(m_step);
        w.wl = run_channel(0, sl, phase, m_base_l, m_depth_l);
        w.wr = run_channel(1, sr, phase + m_offset, m_base_r, m_depth_r);
        slot = (slot + 1) % DEPTH;
        return w;
    endfunction

    task automatic settle();
        while (wet_queue.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_PHASE_STEP: m_step = val[23:0];
            CFG_DEPTH_L:    m_depth_l = val[17:0];
            CFG_DEPTH_R:    m_depth_r = val[17:0];
            CFG_BASE_L:     m_base_l = val[19:0];
            CFG_BASE_R:     m_base_r = val[19:0];
            CFG_PHASE_OFF:  m_offset = val;
            CFG_WAVE_MIX:   m_mix = val[16:0];
            CFG_FEEDBACK:   m_fb = val[15:0];
            default: ;
        endcase
    endtask

    // send one dry word; caller sets gap behaviour
    task automatic send_word(logic signed [23:0] sl, logic signed [23:0] sr, bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) g = 0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample_left <= sl;
        in_ch.sample_right <= sr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        wet_queue.push_back(predict_wet(sl, sr));
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic rand_config();
        write_reg(CFG_PHASE_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400000));
        write_reg(CFG_DEPTH_L, $urandom_range(0, 131072));
        write_reg(CFG_DEPTH_R, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
        write_reg(CFG_BASE_L, $urandom_range(256, 655360));
        write_reg(CFG_BASE_R, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(256, 20000));
        write_reg(CFG_PHASE_OFF, $urandom);
        write_reg(CFG_WAVE_MIX, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
        write_reg(CFG_FEEDBACK, $urandom);
    endtask

    // extremes of the samples and of every register
    task automatic test_directed();
        send_word(24'sh7FFFFF, 24'sh800000, 0);
        send_word(24'sh800000, 24'sh7FFFFF, 0);
        send_word(24'sh000000, 24'shFFFFFF, 0);
        settle();
        write_reg(CFG_PHASE_STEP, 32'h00FF_FFFF);
        write_reg(CFG_DEPTH_L, 32'd131072);
        write_reg(CFG_DEPTH_R, 32'h0003_FFFF);
        write_reg(CFG_BASE_L, 32'd256);
        write_reg(CFG_BASE_R, 32'h000F_FFFF);
        write_reg(CFG_PHASE_OFF, 32'hFFFF_FFFF);
        write_reg(CFG_WAVE_MIX, 32'h0001_FFFF);
        write_reg(CFG_FEEDBACK, 32'h0000_7FFF);
        for (int i = 0; i < 8; i++) send_word(rand_sample(), rand_sample(), 0);
        settle();
        write_reg(CFG_BASE_L, 32'd0);
        write_reg(CFG_DEPTH_L, 32'd0);
        write_reg(CFG_FEEDBACK, 32'h0000_8000);
        write_reg(CFG_WAVE_MIX, 32'd65536);
        write_reg(CFG_PHASE_STEP, 32'h0080_0000);
        write_reg(CFG_PHASE_OFF, 32'h8000_0000);
        // wide data on a register drops upper bits
        write_reg(CFG_DEPTH_R, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send_word(24'sh7FFFFF, 24'sh800000, 0);
        settle();
        write_reg(CFG_WAVE_MIX, 32'd32768);
        write_reg(CFG_BASE_L, 32'd655360);
        write_reg(CFG_DEPTH_L, 32'd0);
        write_reg(CFG_PHASE_STEP, 32'd0);
        for (int i = 0; i < 4; i++) send_word(rand_sample(), rand_sample(), 0);
        settle();
    endtask

    // random phases of words under random register settings
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            rand_config();
            for (int i = 0; i < per_phase; i++) send_word(rand_sample(), rand_sample(), 1);
            settle();
        end
    endtask

    // receiver holds off while the sender keeps offering, then takes every word
    task automatic test_backpressure();
        hold_rx = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 20; i++) send_word(rand_sample(), rand_sample(), 0);
        join
        settle();
        quiet_rx = 1;
        for (int i = 0; i < 60; i++) send_word(rand_sample(), rand_sample(), 0);
        settle();
        quiet_rx = 0;
    endtask

    // receiver ready
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) out_ch.ready <= 1'b0;
            else if (quiet_rx) out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 2) == 0) out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 40) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else out_ch.ready <= 1'b1;
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_wet exp_w;
        if (i_rst_n && (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (wet_queue.size() == 0) begin
                $display("%0t: unexpected wet word %h %h", $time,
                         out_ch.wet_left, out_ch.wet_right);
                errors++;
            end else begin
                exp_w = wet_queue.pop_front();
                if (out_ch.wet_left !== exp_w.wl) begin
                    $display("%0t: wet_left expected %h actual %h", $time,
                             exp_w.wl, out_ch.wet_left);
                    errors++;
                end
                if (out_ch.wet_right !== exp_w.wr) begin
                    $display("%0t: wet_right expected %h actual %h", $time,
                             exp_w.wr, out_ch.wet_right);
                    errors++;
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_stereo_chorus_delay_core: FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample_left = '0;
        in_ch.sample_right = '0;
        for (int i = 0; i <= ENTRIES; i++) sine_tab[i] = quarter_sine(i);
        for (int i = 0; i < DEPTH; i++) begin
            line_l[i] = '0;
            line_r[i] = '0;
        end
        slot = 0;
        phase = '0;
        m_step = RST_PHASE_STEP;
        m_depth_l = '0;
        m_depth_r = '0;
        m_base_l = RST_BASE;
        m_base_r = RST_BASE;
        m_offset = RST_PHASE_OFF;
        m_mix = '0;
        m_fb = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(12, 140);
        test_backpressure();
        repeat (50) @(negedge i_clk);
        if (errors == 0 && wet_queue.size() == 0)
            $display("tb_stereo_chorus_delay_core: PASS");
        else
            $display("tb_stereo_chorus_delay_core: FAIL");
        $finish;
    end

endmodule
